// File: sv/cal_pkg.sv
// ============================================================================
// cal_pkg - shared types, codes and calendar helpers
// Field widths, operation and status codes, the date record passed between
// stages, and the leap-year, month-length and Zeller month-term functions.
// ============================================================================
package cal_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [WDAY_W-1:0]  wday_t;

    // Highest year the counter holds; advancing past its last day is held.
    localparam year_t YEAR_MAX = 14'd9999;

    localparam year_t  RESET_YEAR  = 14'd2001;
    localparam month_t RESET_MONTH = 4'd1;
    localparam day_t   RESET_DAY   = 5'd1;

    localparam month_t MONTH_FEB = 4'd2;
    localparam month_t MONTH_DEC = 4'd12;
    localparam day_t   DAY_LAST  = 5'd31;

    // Multiplicative inverse of 25 modulo 2^14, and the largest quotient
    // y / 25 for a 14-bit y; y is a multiple of 25 exactly when
    // (y * INV_25) mod 2^14 does not exceed that bound.
    localparam year_t INV_25     = 14'd7209;
    localparam year_t DIV25_LIM  = 14'd655;

    // floor(y / 100) = (y * RECIP_100) >> RECIP_SHIFT, exact for 14-bit y.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    typedef enum logic [OP_W-1:0] {
        OP_ADVANCE = 2'd0,
        OP_LOAD    = 2'd1,
        OP_QUERY   = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LOAD = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        year_t   year;
        month_t  month;
        day_t    day;
        status_t status;
    } date_t;

    function automatic logic div_by_25(input year_t y);
        logic [2*YEAR_W-1:0] p;
        p = y * INV_25;
        return p[YEAR_W-1:0] <= DIV25_LIM;
    endfunction

    // Divisible by 100 is divisible by 4 and 25; by 400 is by 16 and 25.
    function automatic logic is_leap(input year_t y);
        return (y[1:0] == 2'b00) && (!div_by_25(y) || (y[3:0] == 4'b0000));
    endfunction

    function automatic day_t month_length(input year_t y, input month_t m);
        day_t len;
        case (m)
            4'd2:                       len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    // (13 * (x + 1)) / 5, where January and February count as 13 and 14.
    function automatic logic [5:0] zeller_mterm(input month_t m);
        logic [5:0] t;
        case (m)
            4'd0:    t = 6'd33;
            4'd1:    t = 6'd36;
            4'd2:    t = 6'd39;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd41;
        endcase
        return t;
    endfunction

endpackage

// File: sv/cal_date_step.sv
// ============================================================================
// cal_date_step - input register and date state update
// Registers one command beat, then advances, loads or reads the stored date
// and registers the new date with its status for the weekday stages.
// ============================================================================
module cal_date_step (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [cal_pkg::OP_W-1:0] in_op,
    input  cal_pkg::year_t         in_year,
    input  cal_pkg::month_t        in_month,
    input  cal_pkg::day_t          in_day,
    output logic                   out_valid,
    input  logic                   out_ready,
    output cal_pkg::date_t         out_date
);
    import cal_pkg::*;

    logic              in_valid_reg;
    logic [OP_W-1:0]   op_reg;
    year_t             ly_reg;
    month_t            lm_reg;
    day_t              ld_reg;

    year_t             year_reg,   year_next;
    month_t            month_reg,  month_next;
    day_t              day_reg,    day_next;
    status_t           status_reg, status_next;
    logic              out_valid_reg;

    day_t              cur_len;
    day_t              load_len;
    logic              take;

    assign take     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg <= in_op;
            ly_reg <= in_year;
            lm_reg <= in_month;
            ld_reg <= in_day;
        end
    end

    always_comb
    begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        status_next = ST_OK;
        cur_len     = month_length(year_reg, month_reg);
        load_len    = month_length(ly_reg, lm_reg);
        case (op_reg)
            OP_ADVANCE:
            begin
                if (year_reg >= YEAR_MAX && month_reg >= MONTH_DEC && day_reg >= DAY_LAST)
                begin
                    status_next = ST_OVERFLOW;
                end
                else if (day_reg >= cur_len)
                begin
                    day_next = RESET_DAY;
                    if (month_reg >= MONTH_DEC)
                    begin
                        month_next = RESET_MONTH;
                        year_next  = year_reg + YEAR_W'(1);
                    end
                    else
                    begin
                        month_next = month_reg + MONTH_W'(1);
                    end
                end
                else
                begin
                    day_next = day_reg + DAY_W'(1);
                end
            end
            OP_LOAD:
            begin
                if (ly_reg == '0 || ly_reg > YEAR_MAX || lm_reg == '0 ||
                    lm_reg > MONTH_DEC || ld_reg == '0 || ld_reg > load_len)
                begin
                    status_next = ST_BAD_LOAD;
                end
                else
                begin
                    year_next  = ly_reg;
                    month_next = lm_reg;
                    day_next   = ld_reg;
                end
            end
            OP_QUERY:
            begin
                // hold the date
            end
            default:
            begin
                // unused code reads like a query
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg      <= RESET_YEAR;
            month_reg     <= RESET_MONTH;
            day_reg       <= RESET_DAY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                year_reg  <= year_next;
                month_reg <= month_next;
                day_reg   <= day_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg <= status_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_date.year   = year_reg;
    assign out_date.month  = month_reg;
    assign out_date.day    = day_reg;
    assign out_date.status = status_reg;

    a_month_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        month_reg != '0 && month_reg <= MONTH_DEC && day_reg != '0)
        else $error("stored date left the valid range");

    a_reject_holds_date: assert property (@(posedge clk) disable iff (!rst_n)
        take && status_next != ST_OK |=>
        year_reg == $past(year_reg) && month_reg == $past(month_reg) &&
        day_reg == $past(day_reg))
        else $error("rejected or overflowed step changed the date");

    a_idle_holds_date: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(year_reg) && $stable(month_reg) && $stable(day_reg))
        else $error("date changed without a command");

endmodule

// File: sv/cal_weekday.sv
// ============================================================================
// cal_weekday - Zeller weekday stages and result register
// Splits the adjusted year into century and year of century over two
// registered stages and reduces the Zeller sum modulo seven.
// ============================================================================
module cal_weekday (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cal_pkg::date_t  in_date,
    output logic            out_valid,
    input  logic            out_ready,
    output cal_pkg::date_t  out_date,
    output cal_pkg::wday_t  out_weekday
);
    import cal_pkg::*;

    // Stage A: adjusted year, century, month term
    logic         a_valid_reg;
    date_t        a_date_reg;
    year_t        a_yy_reg;
    logic [7:0]   a_j_reg;
    logic [5:0]   a_mterm_reg;

    // Stage B: result
    logic         b_valid_reg;
    date_t        b_date_reg;
    wday_t        b_wday_reg;

    year_t        yy;
    logic [26:0]  prod;
    logic         a_load;
    logic         b_load;

    year_t        hundreds;
    year_t        k_wide;
    logic [6:0]   k;
    logic [10:0]  h;
    logic [4:0]   fold1;
    logic [3:0]   fold2;
    wday_t        wday;

    assign b_load   = a_valid_reg && (!b_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || b_load;
    assign a_load   = in_valid && in_ready;

    always_comb
    begin
        if (in_date.month <= MONTH_FEB)
        begin
            yy = (in_date.year == '0) ? '0 : in_date.year - YEAR_W'(1);
        end
        else
        begin
            yy = in_date.year;
        end
        prod = yy * RECIP_100;
    end

    always_comb
    begin
        hundreds = YEAR_W'(a_j_reg) * YEAR_W'(100);
        k_wide   = a_yy_reg - hundreds;
        k        = k_wide[6:0];
        h        = 11'(a_date_reg.day) + 11'(a_mterm_reg) + 11'(k) + 11'(k[6:2]) +
                   11'(a_j_reg[7:2]) + 11'(a_j_reg) * 11'd5;
        // 8 = 1 mod 7: fold octal digits, then one subtract
        fold1    = 5'(h[2:0]) + 5'(h[5:3]) + 5'(h[8:6]) + 5'(h[10:9]);
        fold2    = 4'(fold1[2:0]) + 4'(fold1[4:3]);
        wday     = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_load)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_date_reg  <= in_date;
            a_yy_reg    <= yy;
            a_j_reg     <= prod[RECIP_SHIFT+7:RECIP_SHIFT];
            a_mterm_reg <= zeller_mterm(in_date.month);
        end
        if (b_load)
        begin
            b_date_reg <= a_date_reg;
            b_wday_reg <= wday;
        end
    end

    assign out_valid   = b_valid_reg;
    assign out_date    = b_date_reg;
    assign out_weekday = b_wday_reg;

    a_wday_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> b_wday_reg <= 3'd6)
        else $error("weekday out of range");

    a_year_split: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> k_wide < 14'd100)
        else $error("year of century out of range");

endmodule

// File: sv/calendar_date_counter.sv
// ============================================================================
// calendar_date_counter - Gregorian date counter with Zeller weekday
// Holds year, month and day; each command beat advances one day, loads a
// checked date, or queries. Each beat returns the date, weekday and status.
// ============================================================================
//
//  Channel   Direction  Payload
//  s_*       in         tuser: operation; tdata: load_year, load_month, load_day
//  m_*       out        tuser: status; tdata: cur_year, cur_month, cur_day, weekday
//
// One command beat per cycle sustained while m_tready stays high; a result passes
// through the input register, date update, Zeller split and result register.
// The date state updates at the second of these, so back-to-back commands see
// each other's effect with no gap.
// rst_n (asynchronous, active low) sets 2001-01-01 and empties all stages.
// A stall on m_tready fills each stage in turn; s_tready drops only when all
// stages hold a beat.
//
module calendar_date_counter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // load_year[13:0], load_month[17:14], load_day[22:18], pad
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cur_year[13:0], cur_month[17:14], cur_day[22:18],
                                   // weekday[25:23], pad
    output logic [1:0]  m_tuser    // status[1:0]
);
    import cal_pkg::*;

    // Hand-off from the date state to the weekday stages
    logic   step_valid;
    logic   step_ready;
    date_t  step_date;

    date_t  res_date;
    wday_t  res_wday;

    // Register the command and update the stored date
    cal_date_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_year   (s_tdata[13:0]),
        .in_month  (s_tdata[17:14]),
        .in_day    (s_tdata[22:18]),
        .out_valid (step_valid),
        .out_ready (step_ready),
        .out_date  (step_date)
    );

    // Derive the weekday of the updated date and hold the result beat
    cal_weekday u_wday (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (step_valid),
        .in_ready    (step_ready),
        .in_date     (step_date),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_date    (res_date),
        .out_weekday (res_wday)
    );

    // Pack the result beat, lowest field first
    assign m_tdata = {6'b0, res_wday, res_date.day, res_date.month, res_date.year};
    assign m_tuser = res_date.status;

endmodule

// File: bench/calendar_date_counter_tb.sv
// ============================================================================
// calendar_date_counter_tb - self-checking bench for the date counter
// Drives command beats from a queue and predicts every result beat: date,
// weekday and status. Results are checked in order against that prediction.
// Covers month, year and leap-year rollover, rejected loads, the year
// overflow hold and the unused selector. The run steps through several
// idle and stall patterns and includes one long output hold-off.
// ============================================================================
module calendar_date_counter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cal_pkg::*;

    // Selector value with no operation behind it; the block treats it as a query.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RUN_ITEMS    = 225;     // fewest random command beats queued per idling phase
    localparam int HOLD_LEN     = 80;      // long output hold-off, in cycles
    localparam int DRAIN_CYCLES = 12;      // pipeline depth plus margin
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [OP_W-1:0] op;
        year_t           year;
        month_t          month;
        day_t            day;
    } date_cmd_t;

    typedef struct {
        year_t   year;
        month_t  month;
        day_t    day;
        wday_t   wday;
        status_t status;
    } date_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // load_year[13:0], load_month[17:14], load_day[22:18], pad
    logic [1:0]  s_tuser = '0;     // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // cur_year[13:0], cur_month[17:14], cur_day[22:18],
                                   // weekday[25:23], pad
    logic [1:0]  m_tuser;          // status[1:0]

    date_cmd_t    cmd_q[$];            // command beats not yet taken by the block
    date_result_t expected_dates[$];   // predicted result beats, oldest first
    date_result_t want;

    // Predicted calendar state, starts at the reset date.
    year_t  cal_year  = RESET_YEAR;
    month_t cal_month = RESET_MONTH;
    day_t   cal_day   = RESET_DAY;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  beat_taken     = 1'b0;
    bit  hold_req       = 1'b0;
    int  hold_left      = 0;
    int  fail_count     = 0;
    int  cycle_count    = 0;

    calendar_date_counter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Calendar prediction
    // ------------------------------------------------------------------------

    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_days(int unsigned y, int unsigned m);
        if (m == MONTH_FEB)
            return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // Zeller's congruence: January and February count as months 13 and 14
    // of the year before. 0 is Saturday.
    function automatic wday_t zeller_weekday(int unsigned y, int unsigned m,
                                             int unsigned d);
        int unsigned mm;
        int unsigned yy;
        int unsigned cent;
        int unsigned yoc;
        mm = m;
        yy = y;
        if (m <= MONTH_FEB)
        begin
            mm = m + 12;
            yy = (y > 0) ? y - 1 : 0;
        end
        cent = yy / 100;
        yoc  = yy % 100;
        return wday_t'((d + (13 * (mm + 1)) / 5 + yoc + yoc / 4 + cent / 4 + 5 * cent) % 7);
    endfunction

    // Apply one command to the predicted date and return the result beat.
    function automatic date_result_t step_calendar(date_cmd_t cmd);
        date_result_t res;
        res.status = ST_OK;
        if (cmd.op == OP_ADVANCE)
        begin
            if (cal_year >= YEAR_MAX && cal_month >= MONTH_DEC && cal_day >= DAY_LAST)
                res.status = ST_OVERFLOW;
            else if (cal_day >= month_days(cal_year, cal_month))
            begin
                cal_day = 5'd1;
                if (cal_month >= MONTH_DEC)
                begin
                    cal_month = 4'd1;
                    cal_year  = cal_year + 14'd1;
                end
                else
                    cal_month = cal_month + 4'd1;
            end
            else
                cal_day = cal_day + 5'd1;
        end
        else if (cmd.op == OP_LOAD)
        begin
            if (cmd.year == 0 || cmd.year > YEAR_MAX || cmd.month == 0 ||
                cmd.month > MONTH_DEC || cmd.day == 0 ||
                cmd.day > month_days(cmd.year, cmd.month))
                res.status = ST_BAD_LOAD;
            else
            begin
                cal_year  = cmd.year;
                cal_month = cmd.month;
                cal_day   = cmd.day;
            end
        end
        res.year  = cal_year;
        res.month = cal_month;
        res.day   = cal_day;
        res.wday  = zeller_weekday(cal_year, cal_month, cal_day);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void queue_cmd(logic [OP_W-1:0] op, int unsigned y,
                                      int unsigned m, int unsigned d);
        date_cmd_t cmd;
        cmd.op    = op;
        cmd.year  = year_t'(y);
        cmd.month = month_t'(m);
        cmd.day   = day_t'(d);
        cmd_q.push_back(cmd);
    endfunction

    // Queue a command whose load fields are random; they only matter for loads.
    function automatic void queue_noise(logic [OP_W-1:0] op);
        queue_cmd(op, $urandom_range(16383), $urandom_range(15), $urandom_range(31));
    endfunction

    // Queue one run and return its length. Most runs load a date close to the
    // end of a month and then advance across the boundary; the rest is noise.
    function automatic int queue_random_run();
        int unsigned y;
        int unsigned m;
        int          steps;
        int          pick;
        if ($urandom_range(99) < 25)
        begin
            steps = $urandom_range(1, 4);
            for (int i = 0; i < steps; i++)
                queue_noise(OP_W'($urandom_range(3)));
            return steps;
        end
        pick = $urandom_range(9);
        if (pick == 0)
            y = $urandom_range(1, 99) * 100;           // century years, leap rule
        else if (pick == 1)
            y = YEAR_MAX;                              // toward the overflow hold
        else
            y = $urandom_range(1, YEAR_MAX);
        if (y == YEAR_MAX && $urandom_range(1) == 1)
            m = MONTH_DEC;
        else if ($urandom_range(3) == 0)
            m = MONTH_FEB;
        else
            m = $urandom_range(1, 12);
        queue_cmd(OP_LOAD, y, m, month_days(y, m) - $urandom_range(2));
        steps = $urandom_range(1, 6);
        for (int i = 0; i < steps; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                queue_noise(OP_ADVANCE);
            else if (pick < 92)
                queue_noise(OP_QUERY);
            else
                queue_noise(OP_UNUSED);
        end
        return steps + 1;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present the head of cmd_q at the falling edge; hold it until taken.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || beat_taken)
        begin
            beat_taken = 1'b0;
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= cmd_q[0].op;
                s_tdata  <= {1'b0, cmd_q[0].day, cmd_q[0].month, cmd_q[0].year};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off counted down here on request.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_LEN;
            hold_req  = 1'b0;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void check_field(string name, int unsigned exp_val,
                                        int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: predict on each taken command, check each taken result.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_dates.push_back(step_calendar(cmd_q.pop_front()));
            beat_taken = 1'b1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_dates.size() == 0)
            begin
                $error("result beat with no command waiting for it");
                fail_count++;
            end
            else
            begin
                want = expected_dates.pop_front();
                check_field("cur_year",  want.year,   m_tdata[13:0]);
                check_field("cur_month", want.month,  m_tdata[17:14]);
                check_field("cur_day",   want.day,    m_tdata[22:18]);
                check_field("weekday",   want.wday,   m_tdata[25:23]);
                check_field("status",    want.status, m_tuser);
            end
        end
    end

    // Abort a run that hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed commands, four idling phases, drain.
    // ------------------------------------------------------------------------
    initial
    begin
        int ph;
        int queued;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, no idling.
        queue_cmd(OP_QUERY, 0, 0, 0);                   // reset date
        queue_noise(OP_ADVANCE);                        // day 1 moves to day 2
        queue_cmd(OP_LOAD, 2000, MONTH_FEB, 28);        // leap year by the 400 rule
        queue_noise(OP_ADVANCE);                        // to Feb 29
        queue_noise(OP_ADVANCE);                        // to Mar 1
        queue_cmd(OP_LOAD, 1900, MONTH_FEB, 29);        // century year without Feb 29
        queue_cmd(OP_LOAD, 2100, MONTH_FEB, 28);
        queue_noise(OP_ADVANCE);                        // straight to Mar 1
        queue_cmd(OP_LOAD, YEAR_MAX, MONTH_DEC, DAY_LAST);
        queue_noise(OP_ADVANCE);                        // overflow, date held
        queue_noise(OP_UNUSED);                         // unused selector reads only
        queue_cmd(OP_LOAD, 0, 6, 15);                   // year zero
        queue_cmd(OP_LOAD, 16383, 6, 15);               // year past the top
        queue_cmd(OP_LOAD, 2024, 0, 15);                // month zero
        queue_cmd(OP_LOAD, 2024, 15, 15);               // month past December
        queue_cmd(OP_LOAD, 2024, 6, 0);                 // day zero
        queue_cmd(OP_LOAD, 2024, 4, 31);                // day past a 30-day month
        queue_cmd(OP_LOAD, 1, 1, 1);                    // first year, previous year is 0
        queue_noise(OP_QUERY);
        queue_cmd(OP_LOAD, 2023, 1, 30);
        queue_noise(OP_ADVANCE);                        // day 30 of a 31-day month
        queue_noise(OP_ADVANCE);                        // into February
        queue_cmd(OP_LOAD, 2023, MONTH_DEC, DAY_LAST);
        queue_noise(OP_ADVANCE);                        // into the next year
        wait (cmd_q.size() == 0);

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            queued = 0;
            while (queued < RUN_ITEMS)
                queued += queue_random_run();
            // Hold the output long enough to fill the block and back up the input.
            if (ph == 0)
                hold_req = 1'b1;
            wait (cmd_q.size() == 0);
        end

        wait (expected_dates.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
sv/cal_pkg.sv
sv/cal_date_step.sv
sv/cal_weekday.sv
sv/calendar_date_counter.sv
bench/calendar_date_counter_tb.sv
